// ----- design/pps_pkg.sv -----
// Package for the PID position servo: widths, register indexes, sequencer states
// and the request structs for the shared multiplier and the serial divider.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package pps_pkg;

  // Field and register widths.
  localparam int POSITION_BITS  = 32;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int INTEGRAL_BITS  = 40;
  localparam int GAIN_BITS      = 24;
  localparam int THRESH_BITS    = 16;
  localparam int HOLD_BITS      = 15;
  localparam int DT_BITS        = 16;
  localparam int CURRENT_BITS   = 16;
  localparam int SPEED_BITS     = 9;

  // Reset values of the configuration registers.
  localparam logic [GAIN_BITS-1:0]   GAIN_P_RESET    = GAIN_BITS'(65536);
  localparam logic [GAIN_BITS-1:0]   GAIN_I_RESET    = GAIN_BITS'(655);
  localparam logic [GAIN_BITS-1:0]   GAIN_D_RESET    = GAIN_BITS'(65536);
  localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET = THRESH_BITS'(5);
  localparam logic [HOLD_BITS-1:0]   HOLDING_RESET   = '0;

  // Error and error difference need one and two extra bits.
  localparam int ERR_BITS  = POSITION_BITS + 1;
  localparam int DIFF_BITS = POSITION_BITS + 2;

  // Every product term is limited in magnitude to 2**60.
  localparam int MAG_LIMIT_LOG = 60;
  localparam int SAT_BITS      = MAG_LIMIT_LOG + 2;
  localparam int SUM_BITS      = SAT_BITS + 2;

  // Shared multiplier: gain (or elapsed time) times a signed operand,
  // taken in chunks from the top down.
  localparam int MULB_BITS    = (DIFF_BITS > INTEGRAL_BITS) ? DIFF_BITS : INTEGRAL_BITS;
  localparam int MUL_CHUNK    = 20;
  localparam int MUL_STEPS    = (MULB_BITS + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int MUL_PAD      = MUL_STEPS * MUL_CHUNK;
  localparam int ACC_BITS     = GAIN_BITS + MULB_BITS;
  localparam int MUL_CNT_BITS = $clog2(MUL_STEPS + 2);
  localparam int MAG_W        = (ACC_BITS > SAT_BITS - 1) ? ACC_BITS : SAT_BITS - 1;
  localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'(1) << MAG_LIMIT_LOG;

  // Serial divider over the magnitude of a limited product.
  localparam int DIVN_BITS    = SAT_BITS - 1;
  localparam int DIV_CNT_BITS = $clog2(DIVN_BITS + 1);

  // Stream and configuration port widths.
  localparam int IN_BITS        = 2 * POSITION_BITS + DT_BITS + CURRENT_BITS;
  localparam int IN_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS       = SPEED_BITS + 3;
  localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = GAIN_BITS;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_THRESHOLD = 3'd3,
    REG_HOLDING   = 3'd4
  } reg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_CHECK,
    S_MUL_I,
    S_WAIT_I,
    S_MUL_P,
    S_WAIT_P,
    S_MUL_D,
    S_WAIT_D,
    S_MUL_G,
    S_WAIT_G,
    S_SUM,
    S_SUM2,
    S_CLAMP,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic                        start;
    logic [GAIN_BITS-1:0]        a;
    logic signed [MULB_BITS-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                       start;
    logic signed [SAT_BITS-1:0] numer;
    logic [DT_BITS-1:0]         divisor;
  } div_req_t;

endpackage

`default_nettype wire

// ----- design/pid_position_servo.sv -----
// Top level of the PID position servo: configuration registers, sequencer, loop state
// and output register. Depends on pps_pkg, pps_mul and pps_div.
//
//   Channel  Signals                              Direction  Payload
//   s_*      s_tvalid, s_tready, s_tdata[95:0]    in         one control sample
//   m_*      m_tvalid, m_tready, m_tdata[15:0]    out        drive command and flags
//   cfg_*    cfg_valid, cfg_ready, cfg_index,     in         register write
//            cfg_data[23:0]
//
// A sample that is within the reach threshold passes through the error, check and final
// steps before s_tready rises again. A PID run with a nonzero elapsed time spends most of
// its time in the 61-step serial divider of the derivative term; the four products take
// turns on the one shared multiplier, and the divider overlaps the last of them.
// Reset (rst, synchronous) restores the register defaults and clears the target, the
// stored error, the integral and the last speed. A result waits in the output register
// while m_tready is low, and the next sample is taken meanwhile; only the final step of
// that next sample stalls until the waiting result has gone.
`default_nettype none

module pid_position_servo (
  input  logic                                  clk,
  input  logic                                  rst,
  // measured_position, target_position, elapsed_ms, motor_current (lowest bit first)
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [pps_pkg::IN_TDATA_BITS-1:0]     s_tdata,
  // drive_speed, drive_enable, reached, overload, zero fill (lowest bit first)
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [pps_pkg::OUT_TDATA_BITS-1:0]    m_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pps_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [pps_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  // Configuration registers.
  logic [pps_pkg::GAIN_BITS-1:0]   gain_p;
  logic [pps_pkg::GAIN_BITS-1:0]   gain_i;
  logic [pps_pkg::GAIN_BITS-1:0]   gain_d;
  logic [pps_pkg::THRESH_BITS-1:0] reach_threshold;
  logic [pps_pkg::HOLD_BITS-1:0]   holding_current;

  // Loop state that survives from one sample to the next.
  logic signed [pps_pkg::POSITION_BITS-1:0] last_target;
  logic signed [pps_pkg::ERR_BITS-1:0]      last_error;
  logic signed [pps_pkg::INTEGRAL_BITS-1:0] integral;
  logic signed [pps_pkg::SPEED_BITS-1:0]    last_speed;

  // The sample being worked on and the intermediate values of its run.
  logic signed [pps_pkg::POSITION_BITS-1:0] measured;
  logic signed [pps_pkg::POSITION_BITS-1:0] target;
  logic [pps_pkg::DT_BITS-1:0]              dt;
  logic signed [pps_pkg::CURRENT_BITS-1:0]  current;
  logic signed [pps_pkg::ERR_BITS-1:0]      error;
  logic signed [pps_pkg::DIFF_BITS-1:0]     diff;
  logic [pps_pkg::DT_BITS-1:0]              dt_eff;
  logic signed [pps_pkg::SAT_BITS-1:0]      p_term;
  logic signed [pps_pkg::SUM_BITS-1:0]      sum;
  logic signed [pps_pkg::SPEED_BITS-1:0]    speed;
  logic                                     reached_flag;

  // Output register.
  logic                                  out_valid;
  logic signed [pps_pkg::SPEED_BITS-1:0] out_speed;
  logic                                  out_enable;
  logic                                  out_reached;
  logic                                  out_overload;

  pps_pkg::state_t state;
  pps_pkg::state_t state_next;

  pps_pkg::mul_req_t                   mul_req;
  logic                                mul_busy;
  logic signed [pps_pkg::SAT_BITS-1:0] mul_res;
  pps_pkg::div_req_t                   div_req;
  logic                                div_busy;
  logic signed [pps_pkg::SAT_BITS-1:0] div_q;

  logic                                    in_take;
  logic                                    out_free;
  logic [pps_pkg::ERR_BITS-1:0]            err_mag;
  logic                                    reached_now;
  logic                                    new_target;
  logic signed [pps_pkg::SAT_BITS:0]       integ_sum;
  logic                                    integ_ovf;
  logic signed [pps_pkg::INTEGRAL_BITS-1:0] integ_sat;
  logic [pps_pkg::SUM_BITS-1:0]            sum_mag;
  logic                                    speed_sat;
  logic [pps_pkg::SPEED_BITS-2:0]          speed_q;
  logic signed [pps_pkg::SPEED_BITS-1:0]   speed_clamped;
  logic                                    overload_now;
  logic                                    enable_now;

  assign cfg_ready = 1'b1;
  assign in_take   = s_tvalid && s_tready;
  assign out_free  = !out_valid || m_tready;

  // Reached when the error magnitude lies below the threshold.
  assign err_mag     = error[pps_pkg::ERR_BITS-1] ? pps_pkg::ERR_BITS'(-error)
                                                  : pps_pkg::ERR_BITS'(error);
  assign reached_now = err_mag < pps_pkg::ERR_BITS'(reach_threshold);
  assign new_target  = target != last_target;

  // Integral update saturates to its own signed width.
  assign integ_sum = pps_pkg::SAT_BITS'(integral) + mul_res;
  assign integ_ovf = !((&integ_sum[pps_pkg::SAT_BITS:pps_pkg::INTEGRAL_BITS-1]) ||
                       !(|integ_sum[pps_pkg::SAT_BITS:pps_pkg::INTEGRAL_BITS-1]));
  assign integ_sat = integ_ovf ?
      (integ_sum[pps_pkg::SAT_BITS] ? {1'b1, {(pps_pkg::INTEGRAL_BITS-1){1'b0}}}
                                    : {1'b0, {(pps_pkg::INTEGRAL_BITS-1){1'b1}}})
      : integ_sum[pps_pkg::INTEGRAL_BITS-1:0];

  // Drop the fraction bits of the magnitude, clamp to full scale, restore the sign.
  assign sum_mag   = sum[pps_pkg::SUM_BITS-1] ? pps_pkg::SUM_BITS'(-sum)
                                              : pps_pkg::SUM_BITS'(sum);
  assign speed_sat = |sum_mag[pps_pkg::SUM_BITS-1:pps_pkg::GAIN_FRAC_BITS+pps_pkg::SPEED_BITS-1];
  assign speed_q   = speed_sat ? {(pps_pkg::SPEED_BITS-1){1'b1}}
                   : sum_mag[pps_pkg::GAIN_FRAC_BITS +: pps_pkg::SPEED_BITS-1];
  assign speed_clamped = sum[pps_pkg::SUM_BITS-1] ? -$signed({1'b0, speed_q})
                                                  : $signed({1'b0, speed_q});

  // The current reading is judged on every sample.
  assign overload_now = current < 0;
  assign enable_now   = !overload_now &&
                        !(holding_current != '0 && current >= $signed({1'b0, holding_current}));

  pps_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .busy (mul_busy),
    .res  (mul_res)
  );

  pps_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .busy (div_busy),
    .quot (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p          <= pps_pkg::GAIN_P_RESET;
      gain_i          <= pps_pkg::GAIN_I_RESET;
      gain_d          <= pps_pkg::GAIN_D_RESET;
      reach_threshold <= pps_pkg::THRESHOLD_RESET;
      holding_current <= pps_pkg::HOLDING_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pps_pkg::reg_index_t'(cfg_index))
        pps_pkg::REG_GAIN_P:    gain_p <= cfg_data;
        pps_pkg::REG_GAIN_I:    gain_i <= cfg_data;
        pps_pkg::REG_GAIN_D:    gain_d <= cfg_data;
        pps_pkg::REG_THRESHOLD: reach_threshold <= cfg_data[pps_pkg::THRESH_BITS-1:0];
        pps_pkg::REG_HOLDING:   holding_current <= cfg_data[pps_pkg::HOLD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pps_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: the multiplier is started three times for the error times elapsed time,
  // the proportional and the derivative products, then a fourth time for the integral
  // product while the divider, given a nonzero elapsed time, works on the derivative.
  always_comb begin
    state_next       = state;
    s_tready         = 1'b0;
    mul_req          = '0;
    div_req          = '0;
    div_req.numer    = mul_res;
    div_req.divisor  = dt_eff;
    unique case (state)
      pps_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = pps_pkg::S_ERR;
        end
      end
      pps_pkg::S_ERR: state_next = pps_pkg::S_CHECK;
      pps_pkg::S_CHECK: begin
        state_next = reached_now ? pps_pkg::S_FINISH : pps_pkg::S_MUL_I;
      end
      pps_pkg::S_MUL_I: begin
        mul_req.start = 1'b1;
        mul_req.a     = pps_pkg::GAIN_BITS'(dt_eff);
        mul_req.b     = pps_pkg::MULB_BITS'(error);
        state_next    = pps_pkg::S_WAIT_I;
      end
      pps_pkg::S_WAIT_I: begin
        if (!mul_busy) begin
          state_next = pps_pkg::S_MUL_P;
        end
      end
      pps_pkg::S_MUL_P: begin
        mul_req.start = 1'b1;
        mul_req.a     = gain_p;
        mul_req.b     = pps_pkg::MULB_BITS'(error);
        state_next    = pps_pkg::S_WAIT_P;
      end
      pps_pkg::S_WAIT_P: begin
        if (!mul_busy) begin
          state_next = pps_pkg::S_MUL_D;
        end
      end
      pps_pkg::S_MUL_D: begin
        mul_req.start = 1'b1;
        mul_req.a     = gain_d;
        mul_req.b     = pps_pkg::MULB_BITS'(diff);
        state_next    = pps_pkg::S_WAIT_D;
      end
      pps_pkg::S_WAIT_D: begin
        if (!mul_busy) begin
          state_next = pps_pkg::S_MUL_G;
        end
      end
      pps_pkg::S_MUL_G: begin
        // The divider takes the derivative product before the multiplier result changes.
        mul_req.start = 1'b1;
        mul_req.a     = gain_i;
        mul_req.b     = pps_pkg::MULB_BITS'(integral);
        div_req.start = dt_eff != '0;
        state_next    = pps_pkg::S_WAIT_G;
      end
      pps_pkg::S_WAIT_G: begin
        if (!mul_busy && !div_busy) begin
          state_next = pps_pkg::S_SUM;
        end
      end
      pps_pkg::S_SUM:   state_next = pps_pkg::S_SUM2;
      pps_pkg::S_SUM2:  state_next = pps_pkg::S_CLAMP;
      pps_pkg::S_CLAMP: state_next = pps_pkg::S_FINISH;
      pps_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = pps_pkg::S_IDLE;
        end
      end
      default: state_next = pps_pkg::S_IDLE;
    endcase
  end

  // Loop state. A reached sample leaves all of it alone, including the target.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_target <= '0;
      last_error  <= '0;
      integral    <= '0;
      last_speed  <= '0;
    end else begin
      if (state == pps_pkg::S_CHECK && !reached_now && new_target) begin
        last_target <= target;
        last_error  <= '0;
        integral    <= '0;
      end
      if (state == pps_pkg::S_WAIT_I && !mul_busy) begin
        integral <= integ_sat;
      end
      if (state == pps_pkg::S_FINISH && out_free && !reached_flag) begin
        last_error <= error;
        last_speed <= speed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      measured <= s_tdata[pps_pkg::POSITION_BITS-1:0];
      target   <= s_tdata[2*pps_pkg::POSITION_BITS-1:pps_pkg::POSITION_BITS];
      dt       <= s_tdata[2*pps_pkg::POSITION_BITS +: pps_pkg::DT_BITS];
      current  <= s_tdata[2*pps_pkg::POSITION_BITS+pps_pkg::DT_BITS +: pps_pkg::CURRENT_BITS];
    end
    unique case (state)
      pps_pkg::S_ERR: begin
        error <= pps_pkg::ERR_BITS'(target) - pps_pkg::ERR_BITS'(measured);
      end
      pps_pkg::S_CHECK: begin
        // A new target counts as no time elapsed, which also zeroes the derivative.
        reached_flag <= reached_now;
        dt_eff       <= new_target ? '0 : dt;
        speed        <= last_speed;
      end
      pps_pkg::S_MUL_I: begin
        diff <= pps_pkg::DIFF_BITS'(error) - pps_pkg::DIFF_BITS'(last_error);
      end
      pps_pkg::S_WAIT_P: begin
        if (!mul_busy) begin
          p_term <= mul_res;
        end
      end
      pps_pkg::S_SUM: begin
        sum <= pps_pkg::SUM_BITS'(p_term) + pps_pkg::SUM_BITS'(mul_res);
      end
      pps_pkg::S_SUM2: begin
        if (dt_eff != '0) begin
          sum <= sum + pps_pkg::SUM_BITS'(div_q);
        end
      end
      pps_pkg::S_CLAMP: begin
        speed <= speed_clamped;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        out_valid <= 1'b0;
      end
      if (state == pps_pkg::S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == pps_pkg::S_FINISH && out_free) begin
      out_speed    <= speed;
      out_enable   <= enable_now;
      out_reached  <= reached_flag;
      out_overload <= overload_now;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = pps_pkg::OUT_TDATA_BITS'({out_overload, out_reached, out_enable,
                                              out_speed});

  // The shared units are never restarted while a job is still running.
  a_mul_start_idle: assert property (@(posedge clk) disable iff (rst)
    mul_req.start |-> !mul_busy)
    else $error("multiplier started while busy");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_busy && !mul_busy)
    else $error("divider started while a unit is busy");

  // A result only appears out of the final sequencer step.
  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == pps_pkg::S_FINISH)
    else $error("output written outside the final step");

  // A reached result repeats the speed that the loop still holds.
  a_reached_speed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_reached |-> out_speed == last_speed)
    else $error("reached result does not repeat the last speed");

  a_overload_release: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_overload |-> !out_enable)
    else $error("drive enabled during overload");

endmodule

`default_nettype wire

// ----- design/pps_mul.sv -----
// Shared multiplier of the servo: unsigned gain times signed operand, chunk by chunk,
// with the product magnitude limited to 2**60. Depends on pps_pkg.
`default_nettype none

module pps_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  pps_pkg::mul_req_t                   req,
  output logic                                busy,
  output logic signed [pps_pkg::SAT_BITS-1:0] res
);

  logic [pps_pkg::GAIN_BITS-1:0]                   a_op;
  logic [pps_pkg::MUL_PAD-1:0]                     b_sh;
  logic                                            neg;
  logic [pps_pkg::GAIN_BITS+pps_pkg::MUL_CHUNK-1:0] pp;
  logic [pps_pkg::ACC_BITS-1:0]                    acc;
  logic [pps_pkg::MUL_CNT_BITS-1:0]                cnt;
  logic [pps_pkg::MULB_BITS-1:0]                   b_mag;
  logic [pps_pkg::MAG_W-1:0]                       acc_ext;
  logic [pps_pkg::MAG_W-1:0]                       mag_sat;
  logic [pps_pkg::SAT_BITS-2:0]                    mag_res;

  assign b_mag   = req.b[pps_pkg::MULB_BITS-1] ? pps_pkg::MULB_BITS'(-req.b)
                                               : pps_pkg::MULB_BITS'(req.b);
  assign acc_ext = pps_pkg::MAG_W'(acc);
  assign mag_sat = (acc_ext > pps_pkg::MAG_LIMIT) ? pps_pkg::MAG_LIMIT : acc_ext;
  assign mag_res = mag_sat[pps_pkg::SAT_BITS-2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == pps_pkg::MUL_CNT_BITS'(pps_pkg::MUL_STEPS + 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_op <= req.a;
      b_sh <= pps_pkg::MUL_PAD'(b_mag);
      neg  <= req.b[pps_pkg::MULB_BITS-1];
      acc  <= '0;
    end else if (busy) begin
      if (cnt < pps_pkg::MUL_CNT_BITS'(pps_pkg::MUL_STEPS)) begin
        pp   <= a_op * b_sh[pps_pkg::MUL_PAD-1 -: pps_pkg::MUL_CHUNK];
        b_sh <= b_sh << pps_pkg::MUL_CHUNK;
      end
      if (cnt != '0 && cnt <= pps_pkg::MUL_CNT_BITS'(pps_pkg::MUL_STEPS)) begin
        acc <= {acc[pps_pkg::ACC_BITS-pps_pkg::MUL_CHUNK-1:0], {pps_pkg::MUL_CHUNK{1'b0}}}
               + pps_pkg::ACC_BITS'(pp);
      end
      if (cnt == pps_pkg::MUL_CNT_BITS'(pps_pkg::MUL_STEPS + 1)) begin
        res <= neg ? -$signed({1'b0, mag_res}) : $signed({1'b0, mag_res});
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/pps_div.sv -----
// Serial restoring divider of the servo: signed limited product by the unsigned
// elapsed time, one quotient bit per cycle, truncated toward zero. Depends on pps_pkg.
`default_nettype none

module pps_div (
  input  logic                                clk,
  input  logic                                rst,
  input  pps_pkg::div_req_t                   req,
  output logic                                busy,
  output logic signed [pps_pkg::SAT_BITS-1:0] quot
);

  logic [pps_pkg::DIVN_BITS-1:0]    q_sh;
  logic [pps_pkg::DT_BITS-1:0]      rem;
  logic [pps_pkg::DT_BITS-1:0]      dvs;
  logic                             neg;
  logic [pps_pkg::DIV_CNT_BITS-1:0] cnt;
  logic [pps_pkg::DT_BITS:0]        trial;
  logic                             ge;
  logic [pps_pkg::DT_BITS:0]        diff;
  logic [pps_pkg::SAT_BITS-1:0]     n_mag;

  assign n_mag = req.numer[pps_pkg::SAT_BITS-1] ? pps_pkg::SAT_BITS'(-req.numer)
                                                : pps_pkg::SAT_BITS'(req.numer);
  assign trial = {rem, q_sh[pps_pkg::DIVN_BITS-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == pps_pkg::DIV_CNT_BITS'(pps_pkg::DIVN_BITS)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_sh <= n_mag[pps_pkg::DIVN_BITS-1:0];
      rem  <= '0;
      dvs  <= req.divisor;
      neg  <= req.numer[pps_pkg::SAT_BITS-1];
    end else if (busy) begin
      if (cnt < pps_pkg::DIV_CNT_BITS'(pps_pkg::DIVN_BITS)) begin
        rem  <= ge ? diff[pps_pkg::DT_BITS-1:0] : trial[pps_pkg::DT_BITS-1:0];
        q_sh <= {q_sh[pps_pkg::DIVN_BITS-2:0], ge};
      end else begin
        quot <= neg ? -$signed({1'b0, q_sh}) : $signed({1'b0, q_sh});
      end
    end
  end

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for pid_position_servo: directed samples, then phases of random
// control sequences under several register settings. Depends on pps_pkg and the design.

module tb_top;
  import pps_pkg::*;

  // Run shape.
  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 3;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 205;
  localparam int LONG_HOLD      = 400;   // receiver hold-off that backs the block up
  localparam int SETTLE_CYCLES  = 120;   // a little more than the longest PID run
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transaction

  // Behavioral constants of the loop.
  localparam longint unsigned PRODUCT_CAP = 64'd1 << MAG_LIMIT_LOG;
  localparam longint INTEG_MAX   = (longint'(1) <<< (INTEGRAL_BITS - 1)) - 1;
  localparam longint INTEG_MIN   = -INTEG_MAX - 1;
  localparam longint SPEED_LIMIT = 255;
  localparam longint POS_MAX     = 64'sd2147483647;
  localparam longint POS_MIN     = -POS_MAX - 1;

  // A register index that maps to nothing; writes to it must be ignored.
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic signed [POSITION_BITS-1:0] measured;
    logic signed [POSITION_BITS-1:0] target;
    logic [DT_BITS-1:0]              elapsed;
    logic signed [CURRENT_BITS-1:0]  current;
  } sample_t;

  typedef struct packed {
    logic signed [SPEED_BITS-1:0] speed;
    logic                         enable;
    logic                         reached;
    logic                         overload;
  } drive_t;

  // The scoreboard keeps its own copy of the registers and the loop state, works out the
  // drive command of every accepted sample and compares it with what the block returns.
  class servo_scoreboard;
    longint unsigned kp, ki, kd, near_band, hold_level;
    longint          tgt_prev, err_prev, err_sum, speed_prev;
    drive_t          expected_drive[$];
    int              errors;

    function new();
      kp         = GAIN_P_RESET;
      ki         = GAIN_I_RESET;
      kd         = GAIN_D_RESET;
      near_band  = THRESHOLD_RESET;
      hold_level = HOLDING_RESET;
      tgt_prev   = 0;
      err_prev   = 0;
      err_sum    = 0;
      speed_prev = 0;
      errors     = 0;
    endfunction

    function int pending();
      return expected_drive.size();
    endfunction

    function void set_register(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        REG_GAIN_P:    kp = val;
        REG_GAIN_I:    ki = val;
        REG_GAIN_D:    kd = val;
        REG_THRESHOLD: near_band = val[THRESH_BITS-1:0];
        REG_HOLDING:   hold_level = val[HOLD_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Signed product whose magnitude is capped at 2**60.
    function longint limited_product(longint a, longint b);
      longint unsigned ua, ub, m;
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      if (ua == 0 || ub == 0) return 0;
      if (ua > PRODUCT_CAP / ub) begin
        m = PRODUCT_CAP;
      end else begin
        m = ua * ub;
        if (m > PRODUCT_CAP) m = PRODUCT_CAP;
      end
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function void note_sample(sample_t s);
      longint          err, dt, cur, p, i, d, total, speed;
      longint unsigned err_mag, q;
      bit              hit, overload, enable;
      drive_t          r;
      err     = longint'(s.target) - longint'(s.measured);
      dt      = s.elapsed;
      err_mag = (err < 0) ? -err : err;
      hit     = err_mag < near_band;
      if (hit) begin
        // Inside the band nothing moves, not even the target bookkeeping.
        speed = speed_prev;
      end else begin
        if (longint'(s.target) != tgt_prev) begin
          tgt_prev = s.target;
          err_prev = 0;
          err_sum  = 0;
          dt       = 0;
        end
        err_sum = err_sum + limited_product(err, dt);
        if (err_sum > INTEG_MAX) err_sum = INTEG_MAX;
        if (err_sum < INTEG_MIN) err_sum = INTEG_MIN;
        d = 0;
        if (dt != 0) d = limited_product(longint'(kd), err - err_prev) / dt;
        p        = limited_product(longint'(kp), err);
        i        = limited_product(longint'(ki), err_sum);
        err_prev = err;
        total    = p + i + d;
        q        = ((total < 0) ? -total : total);
        q        = q >> GAIN_FRAC_BITS;
        if (q > SPEED_LIMIT) q = SPEED_LIMIT;
        speed      = (total < 0) ? -longint'(q) : longint'(q);
        speed_prev = speed;
      end
      cur      = s.current;
      overload = cur < 0;
      enable   = !overload && !(hold_level > 0 && cur >= longint'(hold_level));
      r.speed    = speed[SPEED_BITS-1:0];
      r.enable   = enable;
      r.reached  = hit;
      r.overload = overload;
      expected_drive.push_back(r);
    endfunction

    function void check_result(drive_t got);
      drive_t want;
      if (expected_drive.size() == 0) begin
        $display("%0t: unexpected result: speed %0d enable %0b reached %0b overload %0b",
                 $time, got.speed, got.enable, got.reached, got.overload);
        errors++;
        return;
      end
      want = expected_drive.pop_front();
      if (got.speed !== want.speed) begin
        $display("%0t: drive_speed expected %0d, actual %0d", $time, want.speed, got.speed);
        errors++;
      end
      if (got.enable !== want.enable) begin
        $display("%0t: drive_enable expected %0b, actual %0b", $time, want.enable, got.enable);
        errors++;
      end
      if (got.reached !== want.reached) begin
        $display("%0t: reached expected %0b, actual %0b", $time, want.reached, got.reached);
        errors++;
      end
      if (got.overload !== want.overload) begin
        $display("%0t: overload expected %0b, actual %0b", $time, want.overload, got.overload);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_tdata;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  servo_scoreboard sb;

  // Shared between the stimulus and the receiver process.
  bit calm     = 1'b0;   // no idling on either side in the closing phase
  bit hold_req = 1'b0;   // asks the receiver for one long hold-off

  // Current register values that the sample generator aims at.
  logic [HOLD_BITS-1:0] cur_hold = HOLDING_RESET;

  // State of the well-formed control sequence being played.
  int     seq_left = 0;
  longint seq_target, seq_pos;

  int quiet_cycles = 0;

  pid_position_servo dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Offer one sample and hold it until the block takes it. The task returns at the falling
  // edge after the transaction, at times after a gap with tvalid low, unless calm is set.
  task automatic send_sample(input sample_t smp);
    s_tdata  <= IN_TDATA_BITS'({smp.current, smp.elapsed, smp.target, smp.measured});
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_sample(smp);
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  // One register write. Valid drops for a cycle afterwards, so two writes in a row never
  // lower and raise it within the same time step.
  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Registers change only while the block is idle: every result is back and the longest
  // sequencer pass has had time to end.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic sample_t make_sample(longint m, longint t, int unsigned dt, int c);
    sample_t s;
    s.measured = m[POSITION_BITS-1:0];
    s.target   = t[POSITION_BITS-1:0];
    s.elapsed  = dt[DT_BITS-1:0];
    s.current  = c[CURRENT_BITS-1:0];
    return s;
  endfunction

  // Currents: mostly modest positive readings, some right around the release level, and
  // a few raw 16-bit values so that overload and both extremes turn up.
  function automatic logic signed [CURRENT_BITS-1:0] pick_current();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return CURRENT_BITS'($urandom);
    if (r <= 2 && cur_hold != 0) return CURRENT_BITS'(int'(cur_hold) + $urandom_range(0, 2) - 1);
    return CURRENT_BITS'($urandom_range(0, 2000));
  endfunction

  function automatic logic [DT_BITS-1:0] pick_elapsed();
    if ($urandom_range(0, 7) == 0) return '0;
    if ($urandom_range(0, 19) == 0) return DT_BITS'($urandom);
    return DT_BITS'($urandom_range(1, 40));
  endfunction

  // Most random samples belong to a run toward one target, with the position closing in
  // step by step; the rest are raw noise that breaks runs and hits every bit of every field.
  function automatic sample_t next_random_sample();
    sample_t                         s;
    logic signed [POSITION_BITS-1:0] rnd;
    longint                          offset;
    if ($urandom_range(0, 99) < 15) begin
      s.measured = $urandom;
      s.target   = $urandom;
      s.elapsed  = $urandom;
      s.current  = $urandom;
      return s;
    end
    if (seq_left == 0) begin
      rnd        = $urandom;
      seq_target = rnd;
      if ($urandom_range(0, 3) == 0) offset = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
      else offset = longint'($urandom_range(0, 1600)) - 800;
      seq_pos  = seq_target + offset;
      seq_left = $urandom_range(3, 30);
    end
    seq_left--;
    seq_pos = seq_pos + ((seq_target - seq_pos) * longint'($urandom_range(0, 70))) / 100
              + longint'($urandom_range(0, 6)) - 3;
    s.measured = seq_pos[POSITION_BITS-1:0];
    s.target   = seq_target[POSITION_BITS-1:0];
    s.elapsed  = pick_elapsed();
    s.current  = pick_current();
    return s;
  endfunction

  // Register settings of one phase: reset values, all ones, all zeros, full-range random,
  // and then settings that keep the drive mostly out of the clamp.
  task automatic configure_phase(input int ph);
    logic [GAIN_BITS-1:0]   gp, gi, gd;
    logic [THRESH_BITS-1:0] th;
    logic [HOLD_BITS-1:0]   hold;
    case (ph)
      0: begin
        gp = GAIN_P_RESET; gi = GAIN_I_RESET; gd = GAIN_D_RESET;
        th = THRESHOLD_RESET; hold = HOLDING_RESET;
      end
      1: begin
        gp = '1; gi = '1; gd = '1; th = '1; hold = '1;
      end
      2: begin
        gp = '0; gi = '0; gd = '0; th = '0; hold = '0;
      end
      3: begin
        gp = $urandom; gi = $urandom; gd = $urandom; th = $urandom; hold = $urandom;
      end
      default: begin
        gp   = $urandom_range(0, 24'h03_0000);
        gi   = $urandom_range(0, 3000);
        gd   = $urandom_range(0, 24'h08_0000);
        th   = $urandom_range(0, 30);
        hold = ($urandom_range(0, 2) == 0) ? '0 : HOLD_BITS'($urandom_range(1, 3000));
      end
    endcase
    write_register(REG_GAIN_P, gp);
    write_register(REG_GAIN_I, gi);
    write_register(REG_GAIN_D, gd);
    // Bits above a register's width ride along and must be dropped by the block.
    write_register(REG_THRESHOLD, {8'($urandom), th});
    write_register(REG_HOLDING, {9'($urandom), hold});
    if (ph == 4) write_register(REG_UNMAPPED, CFG_DATA_BITS'($urandom));
    cur_hold = hold;
  endtask

  // Receiver: ready drops in short random bursts, and on each request for a long stretch
  // while the sender keeps offering, so the output register and the input side both stall.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
        m_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Every result transaction is unpacked and handed to the scoreboard.
  always @(posedge clk) begin : result_monitor
    drive_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.speed    = m_tdata[SPEED_BITS-1:0];
      got.enable   = m_tdata[SPEED_BITS];
      got.reached  = m_tdata[SPEED_BITS+1];
      got.overload = m_tdata[SPEED_BITS+2];
      sb.check_result(got);
    end
  end

  // Watchdog: a run that stops moving is a failure.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, at reset settings first: inside the band at reset state, a target
    // change hidden by the band, a new target (no time credit), a zero elapsed time on a
    // held target, a repeat of the last speed, an error right at the band edge.
    send_sample(make_sample(0, 0, 10, 100));
    send_sample(make_sample(0, 3, 10, 100));
    send_sample(make_sample(0, 1000, 10, 100));
    send_sample(make_sample(900, 1000, 20, 100));
    send_sample(make_sample(990, 1000, 0, 100));
    send_sample(make_sample(998, 1000, 5, 100));
    send_sample(make_sample(995, 1000, 5, -1));
    // Position extremes: clamp to +255 and -255, the integral running into its limit
    // both ways, and the current extremes.
    send_sample(make_sample(POS_MIN, POS_MAX, 16'hFFFF, 32767));
    send_sample(make_sample(POS_MIN, POS_MAX, 16'hFFFF, 32767));
    send_sample(make_sample(POS_MIN, POS_MAX, 16'hFFFF, -32768));
    send_sample(make_sample(POS_MAX, POS_MIN, 16'hFFFF, 0));
    send_sample(make_sample(POS_MAX, POS_MIN, 16'hFFFF, 0));
    send_sample(make_sample(POS_MAX, POS_MIN, 0, 0));
    send_sample(make_sample(-5, 0, 1, 7));
    send_sample(make_sample(4, 0, 1, 7));

    // A zero band never reports reached; the release current is checked on both sides.
    settle();
    write_register(REG_THRESHOLD, CFG_DATA_BITS'(0));
    write_register(REG_HOLDING, CFG_DATA_BITS'(100));
    cur_hold = 100;
    send_sample(make_sample(0, 0, 3, 99));
    send_sample(make_sample(0, 0, 3, 100));
    send_sample(make_sample(0, 0, 3, 101));
    send_sample(make_sample(1, 0, 3, 0));

    // The widest band.
    settle();
    write_register(REG_THRESHOLD, CFG_DATA_BITS'(16'hFFFF));
    send_sample(make_sample(0, 65534, 3, 50));
    send_sample(make_sample(0, 65535, 3, 50));
    send_sample(make_sample(0, -65534, 3, 50));

    // Random phases, each under its own register setting; the closing phase runs with
    // both sides always ready.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      configure_phase(ph);
      seq_left = 0;
      calm = (ph == PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ((ph == 3 && n == 60) || (ph == 6 && n == 20)) hold_req = 1'b1;
        send_sample(next_random_sample());
      end
    end

    // Drain, then leave room for any stray result before judging the run.
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
